FILE: hdl/clx_pkg.sv
// Package for the calculator language lexer: token kind codes, result item
// type, character classes, operator kinds and the keyword table.
// Depends on nothing.
package clx_pkg;

	localparam int NumKeys = 13;
	localparam int HoldDepth = 6;
	localparam int StackDepth = 16;
	localparam int MaxResults = 8;

	localparam logic [5:0] KIND_EOF     = 6'd0;
	localparam logic [5:0] KIND_NEWLINE = 6'd1;
	localparam logic [5:0] KIND_WS      = 6'd2;
	localparam logic [5:0] KIND_INVALID = 6'd3;
	localparam logic [5:0] KIND_STRING  = 6'd4;
	localparam logic [5:0] KIND_NUMBER  = 6'd5;
	localparam logic [5:0] KIND_LETTER  = 6'd6;
	localparam logic [5:0] KIND_NE      = 6'd7;
	localparam logic [5:0] KIND_MOD     = 6'd8;
	localparam logic [5:0] KIND_LPAREN  = 6'd10;
	localparam logic [5:0] KIND_RPAREN  = 6'd11;
	localparam logic [5:0] KIND_MUL     = 6'd12;
	localparam logic [5:0] KIND_ADD     = 6'd14;
	localparam logic [5:0] KIND_COMMA   = 6'd16;
	localparam logic [5:0] KIND_SUB     = 6'd17;
	localparam logic [5:0] KIND_DIV     = 6'd19;
	localparam logic [5:0] KIND_SEMI    = 6'd21;
	localparam logic [5:0] KIND_LT      = 6'd22;
	localparam logic [5:0] KIND_ASSIGN  = 6'd24;
	localparam logic [5:0] KIND_GT      = 6'd26;
	localparam logic [5:0] KIND_LBRACK  = 6'd28;
	localparam logic [5:0] KIND_RBRACK  = 6'd29;
	localparam logic [5:0] KIND_POW     = 6'd30;
	localparam logic [5:0] KIND_LBRACE  = 6'd32;
	localparam logic [5:0] KIND_RBRACE  = 6'd33;
	localparam logic [5:0] KIND_KEY0    = 6'd34;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_INVALID = 2'd1;
	localparam logic [1:0] ST_UNTERM  = 2'd2;

	typedef struct packed {
		logic [5:0] token_kind;
		logic [7:0] text_byte;
		logic       is_text;
		logic       token_end;
		logic [1:0] status;
	} result_t;

	typedef struct packed {
		logic       exact;
		logic       any;
		logic [3:0] idx;
	} key_res_t;

	localparam logic [7:0] KEY_CHR [NumKeys][HoldDepth] = '{
		'{"a", "u", "t", "o", 8'h00, 8'h00},
		'{"b", "r", "e", "a", "k", 8'h00},
		'{"d", "e", "f", "i", "n", "e"},
		'{"f", "o", "r", 8'h00, 8'h00, 8'h00},
		'{"i", "b", "a", "s", "e", 8'h00},
		'{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"l", "e", "n", "g", "t", "h"},
		'{"o", "b", "a", "s", "e", 8'h00},
		'{"q", "u", "i", "t", 8'h00, 8'h00},
		'{"r", "e", "t", "u", "r", "n"},
		'{"s", "c", "a", "l", "e", 8'h00},
		'{"s", "q", "r", "t", 8'h00, 8'h00},
		'{"w", "h", "i", "l", "e", 8'h00}
	};
	localparam logic [2:0] KEY_LEN [NumKeys] = '{
		3'd4, 3'd5, 3'd6, 3'd3, 3'd5, 3'd2, 3'd6, 3'd5, 3'd4, 3'd6, 3'd5, 3'd4, 3'd5
	};

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_hexup(input logic [7:0] c);
		return c >= "A" && c <= "F";
	endfunction

	function automatic logic is_blank(input logic [7:0] c);
		return c == 8'h20 || c == 8'h09 || c == 8'h0b || c == 8'h0c || c == 8'h0d
			|| c == 8'h5c;
	endfunction

	function automatic logic is_op(input logic [7:0] c);
		return c == "!" || c == "%" || c == "*" || c == "+" || c == "-" || c == "/"
			|| c == "<" || c == "=" || c == ">" || c == "^";
	endfunction

	function automatic logic [5:0] op_kind(input logic [7:0] op, input logic eq);
		logic [5:0] k;
		unique case (op)
			"!":     k = eq ? KIND_NE : KIND_INVALID;
			"%":     k = KIND_MOD + 6'(eq);
			"*":     k = KIND_MUL + 6'(eq);
			"+":     k = KIND_ADD + 6'(eq);
			"-":     k = KIND_SUB + 6'(eq);
			"/":     k = KIND_DIV + 6'(eq);
			"<":     k = KIND_LT + 6'(eq);
			"=":     k = KIND_ASSIGN + 6'(eq);
			">":     k = KIND_GT + 6'(eq);
			default: k = KIND_POW + 6'(eq);
		endcase
		return k;
	endfunction

	function automatic key_res_t key_match(input logic [7:0] cand [HoldDepth],
		input logic [2:0] n);
		key_res_t r;
		logic hit;
		r = '0;
		for (int k = 0; k < NumKeys; k++) begin
			hit = KEY_LEN[k] >= n;
			for (int i = 0; i < HoldDepth; i++) begin
				if (3'(i) < n && cand[i] != KEY_CHR[k][i]) begin
					hit = 1'b0;
				end
			end
			if (hit && KEY_LEN[k] == n) begin
				r.exact = 1'b1;
				r.idx = 4'(k);
			end else if (hit) begin
				r.any = 1'b1;
			end
		end
		return r;
	endfunction

endpackage

FILE: hdl/clx_ifs.sv
// Channel interfaces of the calculator language lexer: source bytes in,
// result items out. Depends on nothing.
interface clx_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

interface clx_tok_if;
	logic       valid;
	logic       ready;
	logic [5:0] token_kind;
	logic [7:0] text_byte;
	logic       is_text;
	logic       token_end;
	logic [1:0] status;
	modport source (output valid, output token_kind, output text_byte, output is_text,
		output token_end, output status, input ready);
	modport sink (input valid, input token_kind, input text_byte, input is_text,
		input token_end, input status, output ready);
endinterface

FILE: hdl/calculator_language_lexer.sv
// Top level of the calculator language lexer: a byte stack, a lexer state and
// a sequencer that processes one byte per cycle unless stalled. Depends on clx_pkg, clx_ifs.
//
// Use: source bytes enter on byte_ch, one item per accepted byte; byte 0 ends
// the text and yields an end-of-text token. Tokens leave on tok_ch as result
// items; string and number tokens stream one item per character and then a
// closing item. Each accepted byte is pushed on a small stack; held bytes that
// must be lexed again are pushed on the same stack. The sequencer pops and
// processes one stacked byte per cycle unless tok_ch stalls it; a byte thus
// enters, each stacked byte is processed, held bytes are pushed back and the
// sequencer returns to idle. byte_ch is not ready while a byte is in process.
// Results go through one output register; when tok_ch stalls, the sequencer
// waits with its next result, which also holds back the byte in process.
// Reset empties the stack and the output register and returns the lexer to
// its idle state, expecting the start of a token.
module calculator_language_lexer (
	input logic clk,
	input logic arst_n,
	clx_byte_if.sink byte_ch,
	clx_tok_if.source tok_ch
);
	import clx_pkg::*;

	typedef enum logic [1:0] {S_IDLE, S_RUN, S_UNLOAD} seq_t;
	typedef enum logic [2:0] {M_IDLE, M_OP, M_WS, M_STR, M_NUM, M_KEY} mode_t;

	seq_t        seq_q;
	mode_t       mode_q, mode_d;
	logic [7:0]  stk_q [StackDepth];
	logic [4:0]  sp_q;
	logic [7:0]  pend_q [HoldDepth];
	logic [2:0]  pcnt_q, pcnt_d;
	logic        point_q, point_d;
	logic        bs_q, bs_d;
	logic [2:0]  uld_q;
	logic [3:0]  rcnt_q;
	logic        ov_q;
	result_t     res_q, res_d;

	logic        emit, pop, push, pend_wr, start_uld;
	logic [7:0]  push_byte;
	logic [7:0]  c;
	logic [7:0]  cand [HoldDepth];
	logic [2:0]  n0, n;
	key_res_t    kr;
	logic        slot_free, go, load;

	assign c = stk_q[4'(sp_q - 5'd1)];
	assign n0 = (mode_q == M_KEY) ? pcnt_q : 3'd0;
	assign n = n0 + 3'd1;

	always_comb begin
		for (int i = 0; i < HoldDepth; i++) begin
			cand[i] = (3'(i) == n0) ? c : pend_q[i];
		end
	end

	assign kr = key_match(cand, n);

	always_comb begin
		emit = 1'b0;
		pop = 1'b1;
		push = 1'b0;
		push_byte = 8'h5c;
		pend_wr = 1'b0;
		start_uld = 1'b0;
		res_d = '{token_kind: KIND_EOF, text_byte: 8'h00, is_text: 1'b0,
			token_end: 1'b1, status: ST_OK};
		mode_d = mode_q;
		pcnt_d = pcnt_q;
		point_d = point_q;
		bs_d = bs_q;
		unique case (mode_q)
			M_OP: begin
				mode_d = M_IDLE;
				pcnt_d = 3'd0;
				emit = 1'b1;
				if (c == "=") begin
					res_d.token_kind = op_kind(pend_q[0], 1'b1);
				end else if (pend_q[0] == "-" && (is_digit(c) || c == ".")) begin
					pop = 1'b0;
					res_d = '{KIND_NUMBER, "-", 1'b1, 1'b0, ST_OK};
					mode_d = M_NUM;
					point_d = 1'b0;
					bs_d = 1'b0;
				end else begin
					pop = 1'b0;
					res_d.token_kind = op_kind(pend_q[0], 1'b0);
					res_d.status = (pend_q[0] == "!") ? ST_INVALID : ST_OK;
				end
			end
			M_WS: begin
				if (!is_blank(c)) begin
					emit = 1'b1;
					pop = 1'b0;
					res_d.token_kind = KIND_WS;
					mode_d = M_IDLE;
				end
			end
			M_STR: begin
				res_d.token_kind = KIND_STRING;
				if (bs_q) begin
					bs_d = 1'b0;
					if (c != 8'h0a) begin
						pop = 1'b0;
						emit = 1'b1;
						res_d = '{KIND_STRING, 8'h5c, 1'b1, 1'b0, ST_OK};
					end
				end else if (c == "\"") begin
					emit = 1'b1;
					mode_d = M_IDLE;
				end else if (c == 8'h00) begin
					emit = 1'b1;
					pop = 1'b0;
					res_d.status = ST_UNTERM;
					mode_d = M_IDLE;
				end else if (c == 8'h5c) begin
					bs_d = 1'b1;
				end else begin
					emit = 1'b1;
					res_d = '{KIND_STRING, c, 1'b1, 1'b0, ST_OK};
				end
			end
			M_NUM: begin
				res_d.token_kind = KIND_NUMBER;
				if (bs_q) begin
					bs_d = 1'b0;
					if (c != 8'h0a) begin
						emit = 1'b1;
						pop = 1'b0;
						push = 1'b1;
						mode_d = M_IDLE;
					end
				end else if (is_digit(c) || is_hexup(c) || (c == "." && !point_q)) begin
					emit = 1'b1;
					res_d = '{KIND_NUMBER, c, 1'b1, 1'b0, ST_OK};
					if (c == ".") begin
						point_d = 1'b1;
					end
				end else if (c == 8'h5c) begin
					bs_d = 1'b1;
				end else begin
					emit = 1'b1;
					pop = 1'b0;
					mode_d = M_IDLE;
				end
			end
			default: begin
				if (mode_q == M_KEY || (c >= "a" && c <= "z")) begin
					pend_wr = 1'b1;
					if (kr.exact) begin
						emit = 1'b1;
						res_d.token_kind = KIND_KEY0 + 6'(kr.idx);
						mode_d = M_IDLE;
						pcnt_d = 3'd0;
					end else if (kr.any) begin
						mode_d = M_KEY;
						pcnt_d = n;
					end else begin
						emit = 1'b1;
						res_d = '{KIND_LETTER, cand[0], 1'b1, 1'b1, ST_OK};
						mode_d = M_IDLE;
						pcnt_d = 3'd0;
						pop = (n == 3'd1);
						start_uld = (n >= 3'd3);
					end
				end else if (c == 8'h00) begin
					emit = 1'b1;
				end else if (c == 8'h0a) begin
					emit = 1'b1;
					res_d.token_kind = KIND_NEWLINE;
				end else if (c == "\"") begin
					mode_d = M_STR;
					bs_d = 1'b0;
				end else if (is_op(c)) begin
					mode_d = M_OP;
					pend_wr = 1'b1;
					pcnt_d = 3'd1;
				end else if (is_blank(c)) begin
					mode_d = M_WS;
				end else if (c == "." || is_digit(c) || is_hexup(c)) begin
					emit = 1'b1;
					res_d = '{KIND_NUMBER, c, 1'b1, 1'b0, ST_OK};
					mode_d = M_NUM;
					point_d = (c == ".");
					bs_d = 1'b0;
				end else begin
					emit = 1'b1;
					priority case (c)
						"(":     res_d.token_kind = KIND_LPAREN;
						")":     res_d.token_kind = KIND_RPAREN;
						",":     res_d.token_kind = KIND_COMMA;
						";":     res_d.token_kind = KIND_SEMI;
						"[":     res_d.token_kind = KIND_LBRACK;
						"]":     res_d.token_kind = KIND_RBRACK;
						"{":     res_d.token_kind = KIND_LBRACE;
						"}":     res_d.token_kind = KIND_RBRACE;
						default: begin
							res_d.token_kind = KIND_INVALID;
							res_d.status = ST_INVALID;
						end
					endcase
				end
			end
		endcase
	end

	assign slot_free = !ov_q || tok_ch.ready;
	assign go = (seq_q == S_RUN) && (sp_q != 5'd0) && (!emit || slot_free);
	assign load = go && emit && (rcnt_q != 4'(MaxResults));

	assign byte_ch.ready = (seq_q == S_IDLE);
	assign tok_ch.valid = ov_q;
	assign tok_ch.token_kind = res_q.token_kind;
	assign tok_ch.text_byte = res_q.text_byte;
	assign tok_ch.is_text = res_q.is_text;
	assign tok_ch.token_end = res_q.token_end;
	assign tok_ch.status = res_q.status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q <= S_IDLE;
			mode_q <= M_IDLE;
			sp_q <= '0;
			pcnt_q <= '0;
			point_q <= 1'b0;
			bs_q <= 1'b0;
			uld_q <= '0;
			rcnt_q <= '0;
			ov_q <= 1'b0;
		end else begin
			if (load) begin
				ov_q <= 1'b1;
			end else if (tok_ch.ready) begin
				ov_q <= 1'b0;
			end
			unique case (seq_q)
				S_IDLE: begin
					if (byte_ch.valid) begin
						stk_q[0] <= byte_ch.in_byte;
						sp_q <= 5'd1;
						rcnt_q <= '0;
						seq_q <= S_RUN;
					end
				end
				S_RUN: begin
					if (sp_q == 5'd0) begin
						seq_q <= S_IDLE;
					end else if (go) begin
						mode_q <= mode_d;
						pcnt_q <= pcnt_d;
						point_q <= point_d;
						bs_q <= bs_d;
						if (pend_wr && n0 < 3'(HoldDepth)) begin
							pend_q[n0] <= c;
						end
						if (load) begin
							res_q <= res_d;
							rcnt_q <= rcnt_q + 4'd1;
						end
						if (pop) begin
							sp_q <= sp_q - 5'd1;
						end else if (push && sp_q != 5'(StackDepth)) begin
							stk_q[sp_q[3:0]] <= push_byte;
							sp_q <= sp_q + 5'd1;
						end
						if (start_uld) begin
							uld_q <= n - 3'd2;
							seq_q <= S_UNLOAD;
						end
					end
				end
				default: begin
					if (sp_q != 5'(StackDepth)) begin
						stk_q[sp_q[3:0]] <= pend_q[uld_q];
						sp_q <= sp_q + 5'd1;
					end
					uld_q <= uld_q - 3'd1;
					if (uld_q == 3'd1) begin
						seq_q <= S_RUN;
					end
				end
			endcase
		end
	end

endmodule

FILE: hdl/clx_checker.sv
// Port checker for the calculator language lexer, bound to the top level.
// Depends on clx_pkg and the top level calculator_language_lexer.
module clx_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [5:0] token_kind,
	input logic [7:0] text_byte,
	input logic       is_text,
	input logic       token_end,
	input logic [1:0] status
);
	import clx_pkg::*;

	a_text_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_text |-> text_byte == 8'h00)
		else $error("Non-text item carries a text byte.");

	a_text_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_text |->
		token_kind == KIND_STRING || token_kind == KIND_NUMBER || token_kind == KIND_LETTER)
		else $error("Text byte on a token kind without text.");

	a_letter: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && token_kind == KIND_LETTER |-> is_text && token_end)
		else $error("Letter item is not a single closing text item.");

	a_status_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> token_end)
		else $error("Error status on an item that does not end its token.");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(token_kind) && $stable(text_byte))
		else $error("Stalled result item changed.");

endmodule

bind calculator_language_lexer clx_checker u_clx_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(tok_ch.valid),
	.out_ready(tok_ch.ready),
	.token_kind(tok_ch.token_kind),
	.text_byte(tok_ch.text_byte),
	.is_text(tok_ch.is_text),
	.token_end(tok_ch.token_end),
	.status(tok_ch.status)
);
